>>> rtl/ognu_pkg.sv
// ognu_pkg: constants and types for the occupancy grid waypoint nudge unit
// no dependencies; used by rtl/occupancy_grid_waypoint_nudge_unit.sv
`timescale 1ns / 1ps

package ognu_pkg;

  // occupancy store and search window
  localparam int MAX_CELLS    = 4096;
  localparam int SEARCH_STEPS = 11;
  localparam int CELL_AW      = $clog2(MAX_CELLS);
  localparam int CNT_W        = $clog2(SEARCH_STEPS);
  localparam int HALF_STEPS   = (SEARCH_STEPS - 1) / 2;
  localparam int STEP_MM      = 100;

  // cell mapping: cell = trunc((mm * cpm_q8 + size * 128000) / 256000)
  localparam int MM_Q8_SCALE = 256000;
  localparam int HALF_Q8_MM  = 128000;
  localparam int GRID_LIMIT  = 128;             // one past the largest grid size
  localparam int DIV_SHIFT   = 11;              // 256000 = 2^11 * 125
  localparam int RECIP_125   = 16778;           // ceil(2^21 / 125)
  localparam int RECIP_SHIFT = 21;

  // configuration register indexes
  localparam logic [1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_GRID_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_CELLS_PER_M = 2'd2;

  localparam logic [6:0]  GRID_WIDTH_RST  = 7'd64;
  localparam logic [6:0]  GRID_HEIGHT_RST = 7'd64;
  localparam logic [15:0] CELLS_PER_M_RST = 16'd2560;

  typedef enum logic [1:0] {
    STAT_FREE    = 2'd0,
    STAT_MOVED   = 2'd1,
    STAT_BLOCKED = 2'd2,
    STAT_OUTSIDE = 2'd3
  } status_t;

endpackage

>>> rtl/occupancy_grid_waypoint_nudge_unit.sv
// occupancy_grid_waypoint_nudge_unit: occupancy bit map with waypoint nudge search
// depends on ognu_pkg (rtl/ognu_pkg.sv)
//
//   channel   handshake              payload
//   cfg       cfg_write              cfg_index, cfg_data
//   in        in_valid / in_ready    action, cell_index, cell_value, x_mm, y_mm
//   out       out_valid / out_ready  adjusted_x_mm, adjusted_y_mm, status
//
// a load request is written as it is taken; the next request is taken in the following cycle
// a waypoint runs its own cell through a 7 stage map-and-read pipeline: out_valid rises
// as the unit returns to idle, and the next request can be taken from then on
// an occupied waypoint streams one candidate a cycle through the same pipeline and
// single read port, over a window of up to SEARCH_STEPS^2 candidates (121 for 11 x 11)
// after reset the map is cleared one cell a cycle, all MAX_CELLS (4096) cells, in_ready low
// a held result does not block loads; a second result waits in DONE until out is free
`timescale 1ns / 1ps

module occupancy_grid_waypoint_nudge_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                action,
  input  logic [11:0]         cell_index,
  input  logic [7:0]          cell_value,
  input  logic signed [15:0]  x_mm,
  input  logic signed [15:0]  y_mm,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [16:0]  adjusted_x_mm,
  output logic signed [16:0]  adjusted_y_mm,
  output logic [1:0]          status
);

  localparam int AW = ognu_pkg::CELL_AW;
  localparam int CW = ognu_pkg::CNT_W;
  localparam logic [CW-1:0] CNT_LAST = CW'(ognu_pkg::SEARCH_STEPS - 1);
  localparam logic [AW-1:0] CLR_LAST = AW'(ognu_pkg::MAX_CELLS - 1);
  localparam logic signed [16:0] START_OFS = 17'(ognu_pkg::HALF_STEPS * ognu_pkg::STEP_MM);
  localparam logic signed [16:0] STEP = 17'(ognu_pkg::STEP_MM);
  localparam logic signed [34:0] NUM_LO = -35'(ognu_pkg::MM_Q8_SCALE);
  localparam logic signed [34:0] NUM_HI = 35'(ognu_pkg::MM_Q8_SCALE * ognu_pkg::GRID_LIMIT);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CENTER,
    ST_SEARCH,
    ST_DONE
  } state_t;

  state_t state;
  logic [6:0]  col_count;
  logic [6:0]  row_count;
  logic [15:0] cells_per_m;
  logic [AW-1:0] clr_cnt;

  logic mem [ognu_pkg::MAX_CELLS];

  logic signed [16:0] wx, wy;
  logic signed [16:0] cand_x, cand_y;
  logic [CW-1:0] ci, cj;
  logic issuing;
  logic signed [16:0] res_x, res_y;
  ognu_pkg::status_t res_status;
  logic [1:0] res_status_out;

  // pipeline: s0 issue, s1 product, s2 bias and scale, s3 reciprocal,
  // s4 bounds, s5 row-major index, s6 memory data
  logic s0_v, s1_v, s2_v, s3_v, s4_v, s5_v, s6_v;
  logic s0_last, s1_last, s2_last, s3_last, s4_last, s5_last, s6_last;
  logic signed [16:0] s0_x, s1_x, s2_x, s3_x, s4_x, s5_x, s6_x;
  logic signed [16:0] s0_y, s1_y, s2_y, s3_y, s4_y, s5_y, s6_y;
  logic signed [33:0] s1_px, s1_py;
  logic [13:0] s2_mx, s2_my;
  logic s2_oobx, s2_ooby, s3_oobx, s3_ooby;
  logic [27:0] s3_rx, s3_ry;
  logic [6:0]  s4_gx, s4_gy;
  logic s4_inb, s5_inb, s6_inb;
  logic [13:0] s5_idx;
  logic s5_beyond, s6_beyond;
  logic s6_occ;

  logic accept;
  logic wp_accept;
  logic load_in_range;
  logic mem_we;
  logic [AW-1:0] mem_waddr;
  logic mem_wdata;
  logic signed [16:0] cpm_s;
  logic [23:0] bias_x, bias_y;
  logic signed [34:0] num_x, num_y;
  logic [14:0] pre_x, pre_y;
  logic [6:0] q_x, q_y;
  logic [13:0] idx_next;
  logic s6_free;
  logic busy;
  logic flush;
  logic cand_issue;
  logic cand_last;
  logic out_load;

  // returns {out of bounds, numerator / 2048, zero if negative} for one coordinate
  function automatic logic [14:0] pre_map(input logic signed [34:0] n);
    logic oob;
    logic [13:0] m;
    oob = (n <= NUM_LO) || (n >= NUM_HI);
    m = n[34] ? 14'd0 : n[24:11];
    return {oob, m};
  endfunction

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign wp_accept = accept && action;
  assign load_in_range = 32'(cell_index) < 32'(ognu_pkg::MAX_CELLS);

  assign mem_we    = (state == ST_CLEAR) || (accept && !action && load_in_range);
  assign mem_waddr = (state == ST_CLEAR) ? clr_cnt : AW'(cell_index);
  assign mem_wdata = (state == ST_CLEAR) ? 1'b0 : (|cell_value);

  assign cpm_s  = $signed({1'b0, cells_per_m});
  assign bias_x = 24'(col_count) * 24'(ognu_pkg::HALF_Q8_MM);
  assign bias_y = 24'(row_count) * 24'(ognu_pkg::HALF_Q8_MM);
  assign num_x  = {s1_px[33], s1_px} + $signed({11'b0, bias_x});
  assign num_y  = {s1_py[33], s1_py} + $signed({11'b0, bias_y});
  assign pre_x  = pre_map(num_x);
  assign pre_y  = pre_map(num_y);
  assign q_x    = s3_rx[27:21];
  assign q_y    = s3_ry[27:21];
  assign idx_next = 14'(s4_gy) * 14'(col_count) + 14'(s4_gx);

  assign s6_free    = s6_inb && !s6_beyond && !s6_occ;
  assign busy       = (state == ST_CENTER) || (state == ST_SEARCH);
  assign flush      = s6_v && busy && ((state == ST_CENTER) || s6_free || s6_last);
  assign cand_issue = (state == ST_SEARCH) && issuing && !flush;
  assign cand_last  = (ci == CNT_LAST) && (cj == CNT_LAST);
  assign out_load   = (state == ST_DONE) && (!out_valid || out_ready);

  assign status = res_status_out;

  // occupancy map: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    s6_occ <= mem[AW'(s5_idx)];
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (wp_accept) begin
      s0_x    <= {x_mm[15], x_mm};
      s0_y    <= {y_mm[15], y_mm};
      s0_last <= 1'b0;
    end else if (cand_issue) begin
      s0_x    <= cand_x;
      s0_y    <= cand_y;
      s0_last <= cand_last;
    end
    s1_x <= s0_x;  s1_y <= s0_y;  s1_last <= s0_last;
    s1_px <= 34'(s0_x) * 34'(cpm_s);
    s1_py <= 34'(s0_y) * 34'(cpm_s);
    s2_x <= s1_x;  s2_y <= s1_y;  s2_last <= s1_last;
    s2_oobx <= pre_x[14];
    s2_ooby <= pre_y[14];
    s2_mx   <= pre_x[13:0];
    s2_my   <= pre_y[13:0];
    s3_x <= s2_x;  s3_y <= s2_y;  s3_last <= s2_last;
    s3_oobx <= s2_oobx;
    s3_ooby <= s2_ooby;
    s3_rx   <= 28'(s2_mx) * 28'(ognu_pkg::RECIP_125);
    s3_ry   <= 28'(s2_my) * 28'(ognu_pkg::RECIP_125);
    s4_x <= s3_x;  s4_y <= s3_y;  s4_last <= s3_last;
    s4_gx  <= q_x;
    s4_gy  <= q_y;
    s4_inb <= !s3_oobx && (q_x < col_count) && !s3_ooby && (q_y < row_count);
    s5_x <= s4_x;  s5_y <= s4_y;  s5_last <= s4_last;
    s5_inb    <= s4_inb;
    s5_idx    <= idx_next;
    s5_beyond <= 32'(idx_next) >= 32'(ognu_pkg::MAX_CELLS);
    s6_x <= s5_x;  s6_y <= s5_y;  s6_last <= s5_last;
    s6_inb    <= s5_inb;
    s6_beyond <= s5_beyond;
  end

  // control, configuration and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_cnt     <= '0;
      col_count   <= ognu_pkg::GRID_WIDTH_RST;
      row_count   <= ognu_pkg::GRID_HEIGHT_RST;
      cells_per_m <= ognu_pkg::CELLS_PER_M_RST;
      issuing     <= 1'b0;
      ci          <= '0;
      cj          <= '0;
      out_valid   <= 1'b0;
      s0_v <= 1'b0; s1_v <= 1'b0; s2_v <= 1'b0; s3_v <= 1'b0;
      s4_v <= 1'b0; s5_v <= 1'b0; s6_v <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          ognu_pkg::CFG_GRID_WIDTH:  col_count   <= cfg_data[6:0];
          ognu_pkg::CFG_GRID_HEIGHT: row_count   <= cfg_data[6:0];
          ognu_pkg::CFG_CELLS_PER_M: cells_per_m <= cfg_data;
          default: ;
        endcase
      end

      s0_v <= wp_accept || cand_issue;
      s1_v <= s0_v && !flush;
      s2_v <= s1_v && !flush;
      s3_v <= s2_v && !flush;
      s4_v <= s3_v && !flush;
      s5_v <= s4_v && !flush;
      s6_v <= s5_v && !flush;

      if (out_load) begin
        out_valid      <= 1'b1;
        adjusted_x_mm  <= res_x;
        adjusted_y_mm  <= res_y;
        res_status_out <= res_status;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      if (cand_issue) begin
        if (cand_last) begin
          issuing <= 1'b0;
        end
        if (cj == CNT_LAST) begin
          cj     <= '0;
          cand_y <= wy - START_OFS;
          ci     <= ci + 1'b1;
          cand_x <= cand_x + STEP;
        end else begin
          cj     <= cj + 1'b1;
          cand_y <= cand_y + STEP;
        end
      end

      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == CLR_LAST) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (wp_accept) begin
            wx    <= {x_mm[15], x_mm};
            wy    <= {y_mm[15], y_mm};
            state <= ST_CENTER;
          end
        end
        ST_CENTER: begin
          if (s6_v) begin
            res_x <= wx;
            res_y <= wy;
            if (!s6_inb) begin
              res_status <= ognu_pkg::STAT_OUTSIDE;
              state      <= ST_DONE;
            end else if (s6_free) begin
              res_status <= ognu_pkg::STAT_FREE;
              state      <= ST_DONE;
            end else begin
              // occupied: open the search window at its lowest x and y offsets
              cand_x  <= wx - START_OFS;
              cand_y  <= wy - START_OFS;
              ci      <= '0;
              cj      <= '0;
              issuing <= 1'b1;
              state   <= ST_SEARCH;
            end
          end
        end
        ST_SEARCH: begin
          if (s6_v) begin
            if (s6_free) begin
              res_x      <= s6_x;
              res_y      <= s6_y;
              res_status <= ognu_pkg::STAT_MOVED;
              issuing    <= 1'b0;
              state      <= ST_DONE;
            end else if (s6_last) begin
              res_x      <= wx;
              res_y      <= wy;
              res_status <= ognu_pkg::STAT_BLOCKED;
              state      <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_no_write_during_read: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> !(s5_v || s6_v))
    else $error("map write while a lookup is in flight");

  a_waypoint_starts: assert property (@(posedge clk) disable iff (rst)
    wp_accept |=> (state == ST_CENTER) && s0_v)
    else $error("waypoint request did not enter the pipeline");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    flush |=> !s6_v && !s5_v && !s1_v)
    else $error("pipeline not flushed after a decision");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid && (state == ST_IDLE))
    else $error("finished result not moved to the output register");

  a_counter_range: assert property (@(posedge clk) disable iff (rst)
    issuing |-> (ci <= CNT_LAST) && (cj <= CNT_LAST))
    else $error("search counter beyond window");
`endif

endmodule
